@@ rtl/core/fpsc_pkg.sv @@
// Package: word types, command codes and register map for the frame packet sequence checker.
`default_nettype none

package fpsc_pkg;

  localparam int unsigned FUNC_W = 3;
  localparam int unsigned BYTES_W = 16;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned NUM_W = 30;
  localparam int unsigned SUB_W = 8;

  // bytes taken off the payload total at each end marker
  localparam logic [31:0] TRAILER_BYTES = 32'd4;

  localparam logic [FUNC_W-1:0] FUNC_START = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PACKET = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RX_ERROR = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RX_ABORT = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_STOP_AFTER = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_STOP_NOW = 3'd5;

  localparam logic [2:0] REG_FRAMES_TO_TAKE = 3'd0;
  localparam logic [2:0] REG_FRAME_BYTES = 3'd1;
  localparam logic [2:0] REG_SUBFRAMES = 3'd2;
  localparam logic [2:0] REG_HEADER_BYTES = 3'd3;
  localparam logic [2:0] REG_COUNTER_CHECK = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTES_W-1:0] byte_count;
    logic [WORD_W-1:0] packet_word;
    logic [WORD_W-1:0] trailer_counter;
  } in_word_t;

  typedef struct packed {
    logic frame_done;
    logic [WORD_W-1:0] frame_number;
    logic acq_complete;
    logic corrupt_flag;
    logic running;
    logic [WORD_W-1:0] frames_counted;
  } out_word_t;

endpackage

`default_nettype wire

@@ rtl/core/frame_packet_sequence_checker.sv @@
// Top level: packet sequence, trailer and frame-size checking with one registered result per word.
`default_nettype none

// One input word is taken per clock while no held result waits untaken, and yields exactly one result word
// in the following cycle. All checks for a word (header subtraction, saturating payload add, trailer removal,
// frame-size compare) run in the single logic stage between the input port and the result register; the next
// word is accepted in the same cycle a held result is taken, so a full-rate stream sustains one word per cycle.
// The user must write registers through the APB port only while idle; the block does not enforce it.
module frame_packet_sequence_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire fpsc_pkg::in_word_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output fpsc_pkg::out_word_t     out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [fpsc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [fpsc_pkg::PDATA_W-1:0] pwdata,
  output logic [fpsc_pkg::PDATA_W-1:0] prdata,
  output logic                    pready
);
  import fpsc_pkg::*;

  // configuration
  logic [31:0] frames_to_take_r;
  logic [31:0] frame_bytes_r;
  logic [SUB_W-1:0] subframes_r;
  logic [15:0] header_bytes_r;
  logic counter_check_r;

  // acquisition state
  logic active_r, active_nxt;
  logic stop_pending_r, stop_pending_nxt;
  logic [31:0] frames_left_r, frames_left_nxt;
  logic [31:0] payload_total_r, payload_total_nxt;
  logic [NUM_W-1:0] packets_in_sub_r, packets_in_sub_nxt;
  logic [SUB_W-1:0] subs_done_r, subs_done_nxt;
  logic [31:0] frames_done_count_r, frames_done_count_nxt;
  logic [31:0] last_frame_id_r, last_frame_id_nxt;
  logic error_latched_r, error_latched_nxt;

  logic out_valid_r;
  out_word_t out_data_r, out_data_nxt;

  logic in_fire;
  logic wr_en;
  logic [2:0] reg_idx;

  logic [15:0] pay;
  logic [32:0] sum;
  logic [31:0] pt_add;
  logic [31:0] pt_cur;
  logic [31:0] want_id;
  logic [SUB_W-1:0] subs_inc;
  logic corrupt, done, complete;
  logic [31:0] fnum;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_comb begin
    case (reg_idx)
      REG_FRAMES_TO_TAKE: prdata = frames_to_take_r;
      REG_FRAME_BYTES: prdata = frame_bytes_r;
      REG_SUBFRAMES: prdata = {24'd0, subframes_r};
      REG_HEADER_BYTES: prdata = {16'd0, header_bytes_r};
      REG_COUNTER_CHECK: prdata = {31'd0, counter_check_r};
      default: prdata = '0;
    endcase
  end

  assign pay = (in_data.byte_count < header_bytes_r) ? 16'd0
                                                     : in_data.byte_count - header_bytes_r;
  assign sum = {1'b0, payload_total_r} + {17'd0, pay};
  assign pt_add = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign want_id = last_frame_id_r + 32'd1;
  assign subs_inc = subs_done_r + 8'd1;

  always_comb begin
    active_nxt = active_r;
    stop_pending_nxt = stop_pending_r;
    frames_left_nxt = frames_left_r;
    payload_total_nxt = payload_total_r;
    packets_in_sub_nxt = packets_in_sub_r;
    subs_done_nxt = subs_done_r;
    frames_done_count_nxt = frames_done_count_r;
    last_frame_id_nxt = last_frame_id_r;
    error_latched_nxt = error_latched_r;
    corrupt = 1'b0;
    done = 1'b0;
    complete = 1'b0;
    fnum = '0;
    pt_cur = pt_add;

    case (in_data.func)
      FUNC_START: begin
        if (!active_r) begin
          active_nxt = 1'b1;
          frames_left_nxt = frames_to_take_r;
          stop_pending_nxt = 1'b0;
          payload_total_nxt = '0;
          packets_in_sub_nxt = '0;
          subs_done_nxt = '0;
          frames_done_count_nxt = '0;
          last_frame_id_nxt = '0;
          error_latched_nxt = 1'b0;
        end
      end
      FUNC_STOP_AFTER: begin
        if (active_r) stop_pending_nxt = 1'b1;
      end
      FUNC_STOP_NOW: begin
        active_nxt = 1'b0;
        stop_pending_nxt = 1'b0;
      end
      FUNC_RX_ABORT: begin
        active_nxt = 1'b0;
      end
      FUNC_RX_ERROR: begin
        corrupt = active_r;
      end
      FUNC_PACKET: begin
        if (in_data.byte_count == 16'd0) begin
          corrupt = active_r;
        end else if (active_r) begin
          if (in_data.byte_count < header_bytes_r) corrupt = 1'b1;
          if (packets_in_sub_r == '0) begin
            if (!in_data.packet_word[31]) corrupt = 1'b1;
            else packets_in_sub_nxt = 30'd1;
          end else begin
            if (in_data.packet_word[NUM_W-1:0] != packets_in_sub_r) corrupt = 1'b1;
            if (in_data.packet_word[30]) begin
              // end of subframe: check or substitute the frame counter
              if (subs_done_r == '0) begin
                if (counter_check_r) begin
                  if (in_data.trailer_counter != want_id) corrupt = 1'b1;
                  last_frame_id_nxt = in_data.trailer_counter;
                end else begin
                  last_frame_id_nxt = want_id;
                end
              end else if (counter_check_r && in_data.trailer_counter != last_frame_id_r) begin
                corrupt = 1'b1;
              end
              pt_cur = (pt_add < TRAILER_BYTES) ? 32'd0 : pt_add - TRAILER_BYTES;
              subs_done_nxt = subs_inc;
              if (subs_inc == subframes_r) begin
                if (pt_cur != frame_bytes_r) corrupt = 1'b1;
                frames_done_count_nxt = frames_done_count_r + 32'd1;
              end
              packets_in_sub_nxt = '0;
            end else begin
              packets_in_sub_nxt = packets_in_sub_r + 30'd1;
            end
          end
          payload_total_nxt = pt_cur;
          if (pt_cur > frame_bytes_r) corrupt = 1'b1;
          if (pt_cur >= frame_bytes_r) begin
            done = 1'b1;
            fnum = last_frame_id_nxt;
            if (stop_pending_r) begin
              active_nxt = 1'b0;
              complete = 1'b1;
            end
            if (frames_left_r == 32'd1) begin
              active_nxt = 1'b0;
              complete = 1'b1;
            end else if (frames_left_r != 32'd0) begin
              frames_left_nxt = frames_left_r - 32'd1;
            end
            payload_total_nxt = '0;
            packets_in_sub_nxt = '0;
            subs_done_nxt = '0;
            error_latched_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase

    out_data_nxt.corrupt_flag = corrupt && !error_latched_nxt;
    if (corrupt) error_latched_nxt = 1'b1;
    out_data_nxt.frame_done = done;
    out_data_nxt.frame_number = fnum;
    out_data_nxt.acq_complete = complete;
    out_data_nxt.running = active_nxt;
    out_data_nxt.frames_counted = frames_done_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_to_take_r <= '0;
      frame_bytes_r <= '0;
      subframes_r <= 8'd1;
      header_bytes_r <= '0;
      counter_check_r <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FRAMES_TO_TAKE: frames_to_take_r <= pwdata;
        REG_FRAME_BYTES: frame_bytes_r <= pwdata;
        REG_SUBFRAMES: subframes_r <= pwdata[SUB_W-1:0];
        REG_HEADER_BYTES: header_bytes_r <= pwdata[15:0];
        REG_COUNTER_CHECK: counter_check_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      stop_pending_r <= 1'b0;
      frames_left_r <= '0;
      payload_total_r <= '0;
      packets_in_sub_r <= '0;
      subs_done_r <= '0;
      frames_done_count_r <= '0;
      last_frame_id_r <= '0;
      error_latched_r <= 1'b0;
    end else if (in_fire) begin
      active_r <= active_nxt;
      stop_pending_r <= stop_pending_nxt;
      frames_left_r <= frames_left_nxt;
      payload_total_r <= payload_total_nxt;
      packets_in_sub_r <= packets_in_sub_nxt;
      subs_done_r <= subs_done_nxt;
      frames_done_count_r <= frames_done_count_nxt;
      last_frame_id_r <= last_frame_id_nxt;
      error_latched_r <= error_latched_nxt;
    end
  end

  // result register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/core/fpsc_checker.sv @@
// Port-level assertions for the frame packet sequence checker, bound to the top level.
`default_nettype none

module fpsc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire fpsc_pkg::in_word_t in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire fpsc_pkg::out_word_t out_data
);
  import fpsc_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_complete_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.acq_complete |-> out_data.frame_done && !out_data.running)
    else $error("acquisition complete without a finished frame or still running");

  a_fnum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_done |-> out_data.frame_number == '0)
    else $error("frame number reported without a finished frame");

  // a result is ready the cycle after a word goes in
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word gave no result");

endmodule

bind frame_packet_sequence_checker fpsc_checker u_fpsc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .in_data(in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data)
);

`default_nettype wire
